@@ design/slm_pkg.sv @@
// Shared types and constants for the sorted list merge block.
// Holds list geometry, func codes, the command struct and queue sizing.
// No dependencies.
`timescale 1ns / 1ps

package slm_pkg;

  // List geometry
  localparam int unsigned LIST_DEPTH = 16;
  localparam int unsigned ADDR_W     = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int unsigned CNT_W      = $clog2(LIST_DEPTH + 1);
  localparam int unsigned SUM_W      = CNT_W + 1;

  // Payload widths
  localparam int unsigned VALUE_W = 64;
  localparam int unsigned FUNC_W  = 2;

  // Command queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // func field codes
  typedef logic [FUNC_W-1:0] func_t;
  localparam func_t FUNC_PUSH_FIRST  = 2'd0;
  localparam func_t FUNC_PUSH_SECOND = 2'd1;
  localparam func_t FUNC_MERGE       = 2'd2;

  // Classified operation handed to the back end
  typedef enum logic [1:0] {
    OP_PUSH_FIRST,
    OP_PUSH_SECOND,
    OP_MERGE
  } op_e;

  typedef struct packed {
    op_e                op;
    logic [VALUE_W-1:0] value;
  } cmd_t;

endpackage

@@ design/sorted_list_merge.sv @@
// An item enters the command queue at acceptance and reaches the back end from the queue
// registers; a merge's first result passes the state register and then the output register.
// A push does not hold the back end; a merge holds it from the queue pop to its final result,
// one result per cycle while the output is not stalled, from the single read port of each store.
// Reset: counts, pointers, queue and output valid clear at once; the stores are not cleared.
// Top level of the sorted list merge; depends on slm_pkg, slm_front and slm_back.
`timescale 1ns / 1ps

module sorted_list_merge (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [slm_pkg::FUNC_W-1:0]  func_i,
  input  logic [slm_pkg::VALUE_W-1:0] value_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [slm_pkg::VALUE_W-1:0] merged_value_o,
  output logic                        last_flag_o
);
  import slm_pkg::*;

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  // Decode and queue incoming transactions
  slm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .func_i      (func_i),
    .value_i     (value_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  // Stores, merge engine and result register
  slm_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (cmd_valid),
    .cmd_ready_o    (cmd_ready),
    .cmd_i          (cmd),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .merged_value_o (merged_value_o),
    .last_flag_o    (last_flag_o)
  );

endmodule

@@ design/slm_front.sv @@
// Front end of the sorted list merge: input handshake, func decode and a
// short command queue towards the back end.
// Depends on slm_pkg.
`timescale 1ns / 1ps

module slm_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [slm_pkg::FUNC_W-1:0]  func_i,
  input  logic [slm_pkg::VALUE_W-1:0] value_i,
  output logic                        cmd_valid_o,
  input  logic                        cmd_ready_i,
  output slm_pkg::cmd_t               cmd_o
);
  import slm_pkg::*;

  cmd_t              queue_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  cmd_t              cmd_new;
  logic              keep;
  logic              enq, deq;

  // Decode func; the unused code is accepted and dropped
  always_comb begin
    cmd_new.value = value_i;
    cmd_new.op    = OP_MERGE;
    keep          = 1'b1;
    case (func_i)
      FUNC_PUSH_FIRST:  cmd_new.op = OP_PUSH_FIRST;
      FUNC_PUSH_SECOND: cmd_new.op = OP_PUSH_SECOND;
      FUNC_MERGE:       cmd_new.op = OP_MERGE;
      default:          keep       = 1'b0;
    endcase
  end

  assign in_ready_o  = (cnt_q != QCNT_W'(QUEUE_DEPTH));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = queue_q[rd_ptr_q];

  assign enq = in_valid_i && in_ready_o && keep;
  assign deq = cmd_valid_o && cmd_ready_i;

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (enq) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
    end
    if (deq) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
    end
    case ({enq, deq})
      2'b10:   cnt_d = cnt_q + QCNT_W'(1);
      2'b01:   cnt_d = cnt_q - QCNT_W'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Queue storage, payload only
  always_ff @(posedge clk_i) begin
    if (enq) begin
      queue_q[wr_ptr_q] <= cmd_new;
    end
  end

  // Fill level never exceeds the queue depth
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCNT_W'(QUEUE_DEPTH))
    else $error("command queue overfilled");

  // A dropped func code leaves the fill level alone when nothing is taken
  a_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && !keep && !deq) |=> $stable(cnt_q))
    else $error("dropped transaction changed queue level");

  // Pointers are consistent with the fill level when empty or full
  a_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0 || cnt_q == QCNT_W'(QUEUE_DEPTH)) |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers disagree with fill level");

endmodule

@@ design/slm_back.sv @@
// Back end of the sorted list merge: the two list stores, their counts, the
// two-pointer merge engine and the output register.
// Depends on slm_pkg.
`timescale 1ns / 1ps

module slm_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cmd_valid_i,
  output logic                        cmd_ready_o,
  input  slm_pkg::cmd_t               cmd_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [slm_pkg::VALUE_W-1:0] merged_value_o,
  output logic                        last_flag_o
);
  import slm_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic               state_q, state_d;
  logic [CNT_W-1:0]   cnt_a_q, cnt_a_d, cnt_b_q, cnt_b_d;
  logic [CNT_W-1:0]   a_q, a_d, b_q, b_d;
  logic [VALUE_W-1:0] mem_a [LIST_DEPTH];
  logic [VALUE_W-1:0] mem_b [LIST_DEPTH];
  logic [VALUE_W-1:0] rd_a_q, rd_b_q;
  logic               wr_a, wr_b;
  logic               pop;
  logic               a_has, b_has, take_a, emit, last;
  logic [SUM_W-1:0]   total, done_next;
  logic               out_valid_q;
  logic [VALUE_W-1:0] out_value_q;
  logic               out_last_q;
  logic               out_free;

  assign cmd_ready_o = (state_q == ST_IDLE);
  assign pop         = cmd_valid_i && cmd_ready_o;

  // Pushes land at the current count unless the list is full
  assign wr_a = pop && (cmd_i.op == OP_PUSH_FIRST)  && (cnt_a_q < CNT_W'(LIST_DEPTH));
  assign wr_b = pop && (cmd_i.op == OP_PUSH_SECOND) && (cnt_b_q < CNT_W'(LIST_DEPTH));

  // Merge step: heads are the registered reads at the current pointers
  assign total     = SUM_W'(cnt_a_q) + SUM_W'(cnt_b_q);
  assign done_next = SUM_W'(a_q) + SUM_W'(b_q) + SUM_W'(1);
  assign a_has     = (a_q < cnt_a_q);
  assign b_has     = (b_q < cnt_b_q);
  assign take_a    = a_has && (!b_has || !(rd_b_q < rd_a_q));
  assign out_free  = !out_valid_q || out_ready_i;
  assign emit      = (state_q == ST_RUN) && out_free;
  assign last      = (done_next == total);

  // Sequencer, counts and pointers
  always_comb begin
    state_d = state_q;
    cnt_a_d = cnt_a_q;
    cnt_b_d = cnt_b_q;
    a_d     = a_q;
    b_d     = b_q;
    case (state_q)
      ST_IDLE: begin
        if (wr_a) cnt_a_d = cnt_a_q + CNT_W'(1);
        if (wr_b) cnt_b_d = cnt_b_q + CNT_W'(1);
        if (pop && (cmd_i.op == OP_MERGE) && (total != '0)) state_d = ST_RUN;
      end
      ST_RUN: begin
        if (emit) begin
          if (take_a) a_d = a_q + CNT_W'(1);
          else        b_d = b_q + CNT_W'(1);
          if (last) begin
            state_d = ST_IDLE;
            cnt_a_d = '0;
            cnt_b_d = '0;
            a_d     = '0;
            b_d     = '0;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_a_q <= '0;
      cnt_b_q <= '0;
      a_q     <= '0;
      b_q     <= '0;
    end else begin
      state_q <= state_d;
      cnt_a_q <= cnt_a_d;
      cnt_b_q <= cnt_b_d;
      a_q     <= a_d;
      b_q     <= b_d;
    end
  end

  // List stores: one write port, one registered read at the next pointer
  always_ff @(posedge clk_i) begin
    if (wr_a) mem_a[cnt_a_q[ADDR_W-1:0]] <= cmd_i.value;
    rd_a_q <= mem_a[a_d[ADDR_W-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (wr_b) mem_b[cnt_b_q[ADDR_W-1:0]] <= cmd_i.value;
    rd_b_q <= mem_b[b_d[ADDR_W-1:0]];
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_value_q <= take_a ? rd_a_q : rd_b_q;
      out_last_q  <= last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign merged_value_o = out_value_q;
  assign last_flag_o    = out_last_q;

  // Read pointers never run past their list
  a_ptr_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_q <= cnt_a_q)
    else $error("first list pointer beyond count");

  a_ptr_b: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_q <= cnt_b_q)
    else $error("second list pointer beyond count");

  // Pointers rest at zero between merges
  a_idle_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (a_q == '0 && b_q == '0))
    else $error("pointers not cleared while idle");

  // The final result of a run clears both lists
  a_last_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && last) |=> (state_q == ST_IDLE && cnt_a_q == '0 && cnt_b_q == '0))
    else $error("lists not cleared after final result");

  // A running merge always has something left to emit
  a_run_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (a_has || b_has))
    else $error("merge running with both lists exhausted");

endmodule
